// File: rtl/core/svc_pkg.sv
// Shared types, constants and the balance table for the stereo volume chain.
package svc_pkg;

  localparam int VOLUME_SCALE  = 1024;
  localparam int HALF_SCALE    = VOLUME_SCALE / 2;
  localparam int BALANCE_STEPS = 15;
  localparam int TABLE_CENTER  = 15;

  typedef logic [16:0]        level_t;
  typedef logic [17:0]        raw_t;
  typedef logic signed [17:0] offset_t;
  typedef logic [4:0]         tab_idx_t;

  typedef enum logic [2:0] {
    REG_USER_VOLUME_LIMIT = 3'd0,
    REG_SOURCE_OFFSET     = 3'd1,
    REG_UNITY_ENABLE      = 3'd2,
    REG_UNITY_LEVEL       = 3'd3,
    REG_BALANCE           = 3'd4,
    REG_OUTPUT_LIMIT      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [6:0]        user_volume_limit;
    logic [14:0]       source_offset;
    logic              unity_enable;
    level_t            unity_level;
    logic signed [4:0] balance;
    level_t            output_limit;
  } cfg_t;

  localparam logic [6:0]        RST_USER_VOLUME_LIMIT = 7'd100;
  localparam logic [14:0]       RST_SOURCE_OFFSET     = 15'd0;
  localparam logic              RST_UNITY_ENABLE      = 1'b0;
  localparam level_t            RST_UNITY_LEVEL       = 17'd81920;
  localparam logic signed [4:0] RST_BALANCE           = 5'sd0;
  localparam level_t            RST_OUTPUT_LIMIT      = 17'd102400;

  // Balance offset in system-level units for one table entry.
  function automatic offset_t bal_offset(input tab_idx_t idx);
    int t;
    unique case (idx)
      5'd0:  t = -200;
      5'd1:  t = -48;
      5'd2:  t = -32;
      5'd3:  t = -25;
      5'd4:  t = -16;
      5'd5:  t = -13;
      5'd6:  t = -11;
      5'd7:  t = -9;
      5'd8:  t = -8;
      5'd9:  t = -6;
      5'd10: t = -5;
      5'd11: t = -4;
      5'd12: t = -3;
      5'd13: t = -2;
      5'd14: t = -1;
      5'd15: t = 0;
      5'd16: t = 1;
      5'd17: t = 2;
      5'd18: t = 2;
      5'd19: t = 3;
      5'd20: t = 3;
      5'd21: t = 4;
      5'd22: t = 4;
      5'd23: t = 5;
      5'd24: t = 5;
      5'd25: t = 5;
      5'd26: t = 5;
      5'd27: t = 5;
      5'd28: t = 6;
      5'd29: t = 6;
      default: t = 6;
    endcase
    return offset_t'(t * HALF_SCALE);
  endfunction

endpackage

// File: rtl/core/svc_cfg_regs.sv
// Configuration register file of the stereo volume chain.
module svc_cfg_regs
  import svc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_volume_limit <= RST_USER_VOLUME_LIMIT;
      cfg.source_offset     <= RST_SOURCE_OFFSET;
      cfg.unity_enable      <= RST_UNITY_ENABLE;
      cfg.unity_level       <= RST_UNITY_LEVEL;
      cfg.balance           <= RST_BALANCE;
      cfg.output_limit      <= RST_OUTPUT_LIMIT;
    end else if (cfg_valid) begin
      // Keep the low bits only; unknown indexes are dropped.
      unique case (cfg_reg_t'(cfg_index))
        REG_USER_VOLUME_LIMIT: cfg.user_volume_limit <= cfg_data[6:0];
        REG_SOURCE_OFFSET:     cfg.source_offset     <= cfg_data[14:0];
        REG_UNITY_ENABLE:      cfg.unity_enable      <= cfg_data[0];
        REG_UNITY_LEVEL:       cfg.unity_level       <= cfg_data;
        REG_BALANCE:           cfg.balance           <= $signed(cfg_data[4:0]);
        REG_OUTPUT_LIMIT:      cfg.output_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/svc_channel.sv
// One channel: balance offset, zero clamp, change detect against the held level, cap.
module svc_channel
  import svc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  raw_t     level,
  input  tab_idx_t tab_idx,
  input  level_t   output_limit,
  output level_t   level_out,
  output logic     update
);

  raw_t               last_raw;
  offset_t            offset;
  logic signed [19:0] sum;
  raw_t               raw;

  always_comb begin
    offset    = bal_offset(tab_idx);
    sum       = $signed({2'b00, level}) + {{2{offset[17]}}, offset};
    raw       = sum[19] ? '0 : sum[17:0];
    update    = (raw != last_raw);
    level_out = (raw > {1'b0, output_limit}) ? output_limit : raw[16:0];
  end

  // Held level follows the new level whenever an item passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= '0;
    end else if (advance) begin
      last_raw <= raw;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(last_raw))
    else $error("held level moved without a transaction");

  a_no_update_keeps: assert property (@(posedge clk) disable iff (rst)
    advance && !update |=> $stable(last_raw))
    else $error("held level changed on a transaction flagged unchanged");

  a_update_changes: assert property (@(posedge clk) disable iff (rst)
    advance && update |=> last_raw != $past(last_raw))
    else $error("transaction flagged as update left the held level as it was");

endmodule

// File: rtl/core/stereo_volume_chain.sv
// Top level of the stereo volume chain: input register, level path and result register.
//
// One user volume request is accepted per clock cycle while in_ready is high (input
// register empty, or result register empty or being read): the request lands in an
// input register, a single pass of clamp, scale, offset (or unity level), per-channel
// balance lookup, zero clamp and output cap runs between that register and the result
// register, and the held per-channel levels update in the same cycle the transaction
// moves into the result register. The input register and the result register each
// hold one transaction, so a new request is taken while a finished result still waits
// to be read. The configuration port is always ready and also reaches a request held
// in the input register; write it only when the chain is empty.
module stereo_volume_chain
  import svc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  user_volume,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] left_level,
  output logic        left_update,
  output logic [16:0] right_level,
  output logic        right_update
);

  cfg_t              cfg;
  logic              s1_valid;
  logic [7:0]        s1_volume;
  logic              out_free;
  logic              advance;
  logic [6:0]        uv_clamped;
  raw_t              scaled;
  raw_t              base_level;
  logic signed [4:0] bal_sat;
  tab_idx_t          left_idx;
  tab_idx_t          right_idx;
  level_t            left_calc;
  level_t            right_calc;
  logic              left_upd_calc;
  logic              right_upd_calc;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  svc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register is free when empty or being read this cycle.
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Input register: hold the request until it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_volume <= user_volume;
    end
  end

  // Common level: clamp, scale, then source offset or unity level.
  always_comb begin
    uv_clamped = (s1_volume > {1'b0, cfg.user_volume_limit}) ?
                 cfg.user_volume_limit : s1_volume[6:0];
    scaled     = raw_t'(18'(uv_clamped) * 18'(VOLUME_SCALE));
    base_level = cfg.unity_enable ? {1'b0, cfg.unity_level}
                                  : scaled + 18'(cfg.source_offset);
  end

  // Saturate balance and pick table entries either side of the centre.
  always_comb begin
    priority if (cfg.balance > 5'(BALANCE_STEPS)) begin
      bal_sat = 5'(BALANCE_STEPS);
    end else if (cfg.balance < -5'(BALANCE_STEPS)) begin
      bal_sat = -5'(BALANCE_STEPS);
    end else begin
      bal_sat = cfg.balance;
    end
    left_idx  = tab_idx_t'(TABLE_CENTER - int'(bal_sat));
    right_idx = tab_idx_t'(TABLE_CENTER + int'(bal_sat));
  end

  svc_channel u_left (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .level        (base_level),
    .tab_idx      (left_idx),
    .output_limit (cfg.output_limit),
    .level_out    (left_calc),
    .update       (left_upd_calc)
  );

  svc_channel u_right (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .level        (base_level),
    .tab_idx      (right_idx),
    .output_limit (cfg.output_limit),
    .level_out    (right_calc),
    .update       (right_upd_calc)
  );

  // Result register: load on advance, drop once read.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_level   <= left_calc;
      left_update  <= left_upd_calc;
      right_level  <= right_calc;
      right_update <= right_upd_calc;
    end
  end

endmodule
